// ===== hw/rtl/mer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Widths, command codes and stream layout shared by the ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int COORD_BITS = 12;
  localparam int OUT_W      = COORD_BITS + 2;      // signed output coordinate
  localparam int RAD_W      = COORD_BITS - 1;      // radius
  localparam int SQ_W       = 2 * RAD_W;           // squared radius
  localparam int MUL_W      = 2 * COORD_BITS + 3;  // signed multiplier operand
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DEC_W      = 4 * COORD_BITS + 2;  // decision variable times 4

  localparam int CMD_W      = 2;
  localparam logic [CMD_W-1:0] CMD_ELLIPSE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CIRCLE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

  // input stream layout
  localparam int IN_BITS  = CMD_W + 4 * COORD_BITS;
  localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int AX_LSB   = CMD_W;
  localparam int AY_LSB   = CMD_W + COORD_BITS;
  localparam int BX_LSB   = CMD_W + 2 * COORD_BITS;
  localparam int BY_LSB   = CMD_W + 3 * COORD_BITS;

  // output stream layout
  localparam int M_BITS   = 4 * OUT_W;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

endpackage

// ===== hw/rtl/mer_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mer_mul (
  input  logic                              clk,
  input  logic signed [mer_pkg::MUL_W-1:0]  a,
  input  logic signed [mer_pkg::MUL_W-1:0]  b,
  output logic signed [mer_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse/circle walker: start commands set up a shape from two
// bounding corners, step commands return one point mirrored into 4 quadrants.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries
//  s_*      in   cmd, corner_a_x, corner_a_y, corner_b_x, corner_b_y
//  m_*      out  right_x, left_x, lower_y, upper_y; tlast = last_point
//
//  A start and a step each run the extra states S_TY, S_A, S_B and S_C when
//  the walk crosses from region 1 to region 2; all products come from one
//  shared multiplier issuing one product per cycle. Dropped commands are accepted and discarded.
//  rst (synchronous) returns the block to idle with no shape loaded.
//  A finished point waits in the output register; s_tready stays high
//  while it waits, and only the next point's final cycle holds for it.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd, corner_a_x, corner_a_y, corner_b_x, corner_b_y, zero pad
  input  logic [mer_pkg::S_DATA_W-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // right_x, left_x, lower_y, upper_y
  output logic [mer_pkg::M_DATA_W-1:0]    m_tdata,
  output logic                            m_tlast
);

  localparam int CB = mer_pkg::COORD_BITS;
  localparam int OW = mer_pkg::OUT_W;
  localparam int MW = mer_pkg::MUL_W;
  localparam int DW = mer_pkg::DEC_W;
  localparam int RW = mer_pkg::RAD_W;
  localparam int QW = mer_pkg::SQ_W;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_RX2  = 15'b000000000000010,
    S_RY2  = 15'b000000000000100,
    S_T    = 15'b000000000001000,
    S_K    = 15'b000000000010000,
    S_INIT = 15'b000000000100000,
    S_MP   = 15'b000000001000000,
    S_MQ   = 15'b000000010000000,
    S_UPD  = 15'b000000100000000,
    S_CHK  = 15'b000001000000000,
    S_TY   = 15'b000010000000000,
    S_A    = 15'b000100000000000,
    S_B    = 15'b001000000000000,
    S_C    = 15'b010000000000000,
    S_FIN  = 15'b100000000000000
  } seq_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_R1   = 4'b0010,
    PH_R2   = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  seq_t   state;
  phase_t phase;

  logic [CB-1:0]        cx, cy, ox;
  logic signed [CB-1:0] oy;
  logic [RW-1:0]        rx, ry;
  logic [QW-1:0]        rx2, ry2;
  logic signed [DW-1:0] decision, p_reg, q_reg, k_reg;
  logic                 is_step, mv_x, mv_y;
  logic [OW-1:0]        pend_right, pend_left, pend_lower, pend_upper;

  logic signed [MW-1:0]             mul_a, mul_b;
  logic signed [mer_pkg::PROD_W-1:0] prod;
  logic signed [DW-1:0]             prod_d;

  // corner decode
  logic [mer_pkg::CMD_W-1:0] cmd;
  logic [CB-1:0]             ax, ay, bx, by, dx, dy;
  logic [CB:0]               sum_x, sum_y;
  logic [RW-1:0]             rx_new, ry_new, rmax;

  // per-point helpers
  logic [CB:0]          tx;
  logic signed [CB:0]   ty;
  logic signed [DW-1:0] rx2_d, ry2_d;
  logic                 dec_neg, dec_pos, done_now, out_free, load_out;

  assign cmd = s_tdata[mer_pkg::CMD_W-1:0];
  assign ax  = s_tdata[mer_pkg::AX_LSB +: CB];
  assign ay  = s_tdata[mer_pkg::AY_LSB +: CB];
  assign bx  = s_tdata[mer_pkg::BX_LSB +: CB];
  assign by  = s_tdata[mer_pkg::BY_LSB +: CB];

  assign dx     = (bx > ax) ? (bx - ax) : (ax - bx);
  assign dy     = (by > ay) ? (by - ay) : (ay - by);
  assign sum_x  = {1'b0, ax} + {1'b0, bx};
  assign sum_y  = {1'b0, ay} + {1'b0, by};
  assign rx_new = dx[CB-1:1];
  assign ry_new = dy[CB-1:1];
  assign rmax   = (ry_new > rx_new) ? ry_new : rx_new;

  assign tx      = {ox, 1'b1};
  assign ty      = {oy[CB-1], oy} - {{CB{1'b0}}, 1'b1};
  assign rx2_d   = {{(DW-QW){1'b0}}, rx2};
  assign ry2_d   = {{(DW-QW){1'b0}}, ry2};
  assign prod_d  = prod[DW-1:0];
  assign dec_neg = decision[DW-1];
  assign dec_pos = !decision[DW-1] && (decision != '0);

  assign done_now = (phase == PH_R2) &&
                    !(({1'b0, rx} >= ox) && !oy[CB-1]);
  assign out_free = !m_tvalid || m_tready;
  assign load_out = (state == S_FIN) && is_step && out_free;

  assign s_tready = (state == S_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RX2: begin
        mul_a = {{(MW-RW){1'b0}}, rx};
        mul_b = {{(MW-RW){1'b0}}, rx};
      end
      S_RY2: begin
        mul_a = {{(MW-RW){1'b0}}, ry};
        mul_b = {{(MW-RW){1'b0}}, ry};
      end
      S_T: begin
        mul_a = {{(MW-QW){1'b0}}, rx2};
        mul_b = {{(MW-RW){1'b0}}, ry};
      end
      S_K: begin
        mul_a = {{(MW-QW){1'b0}}, rx2};
        mul_b = {{(MW-QW){1'b0}}, ry2};
      end
      S_MP: begin
        mul_a = {{(MW-QW){1'b0}}, ry2};
        mul_b = {{(MW-CB){1'b0}}, ox};
      end
      S_MQ: begin
        mul_a = {{(MW-QW){1'b0}}, rx2};
        mul_b = {{(MW-CB){oy[CB-1]}}, oy};
      end
      S_CHK: begin
        mul_a = {{(MW-CB-1){1'b0}}, tx};
        mul_b = {{(MW-CB-1){1'b0}}, tx};
      end
      S_TY: begin
        mul_a = {{(MW-CB-1){ty[CB]}}, ty};
        mul_b = {{(MW-CB-1){ty[CB]}}, ty};
      end
      S_A: begin
        mul_a = {{(MW-QW){1'b0}}, ry2};
        mul_b = p_reg[MW-1:0];
      end
      S_B: begin
        mul_a = {{(MW-QW){1'b0}}, rx2};
        mul_b = q_reg[MW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mer_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IDLE;
      m_tvalid <= 1'b0;
      is_step  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !load_out) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (cmd == mer_pkg::CMD_ELLIPSE || cmd == mer_pkg::CMD_CIRCLE) begin
              cx      <= sum_x[CB:1];
              cy      <= sum_y[CB:1];
              rx      <= (cmd == mer_pkg::CMD_CIRCLE) ? rmax : rx_new;
              ry      <= (cmd == mer_pkg::CMD_CIRCLE) ? rmax : ry_new;
              ox      <= '0;
              oy      <= (cmd == mer_pkg::CMD_CIRCLE) ? {1'b0, rmax} : {1'b0, ry_new};
              phase   <= PH_R1;
              is_step <= 1'b0;
              state   <= S_RX2;
            end else if (cmd == mer_pkg::CMD_STEP && (phase == PH_R1 || phase == PH_R2)) begin
              pend_right <= {2'b00, cx} + {2'b00, ox};
              pend_left  <= {2'b00, cx} - {2'b00, ox};
              pend_lower <= {2'b00, cy} + {{2{oy[CB-1]}}, oy};
              pend_upper <= {2'b00, cy} - {{2{oy[CB-1]}}, oy};
              is_step    <= 1'b1;
              if (phase == PH_R1) begin
                ox   <= ox + CB'(1);
                mv_x <= 1'b1;
                mv_y <= !dec_neg;
                if (!dec_neg) begin
                  oy <= oy - CB'(1);
                end
              end else begin
                oy   <= oy - CB'(1);
                mv_y <= 1'b1;
                mv_x <= !dec_pos;
                if (!dec_pos) begin
                  ox <= ox + CB'(1);
                end
              end
              state <= S_MP;
            end
            // anything else: drop the transaction
          end
        end
        S_RX2: state <= S_RY2;
        S_RY2: begin
          rx2   <= prod[QW-1:0];
          state <= S_T;
        end
        S_T: begin
          ry2   <= prod[QW-1:0];
          state <= S_K;
        end
        S_K: begin
          q_reg    <= prod_d;
          decision <= (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
          state    <= S_INIT;
        end
        S_INIT: begin
          k_reg <= prod_d;
          p_reg <= '0;
          state <= S_CHK;
        end
        S_MP: state <= S_MQ;
        S_MQ: begin
          p_reg <= prod_d;
          state <= S_UPD;
        end
        S_UPD: begin
          q_reg    <= prod_d;
          decision <= decision
                    + (mv_x ? (p_reg <<< 3) : '0)
                    - (mv_y ? (prod_d <<< 3) : '0)
                    + ((phase == PH_R1) ? (ry2_d <<< 2) : (rx2_d <<< 2));
          state    <= S_CHK;
        end
        S_CHK: begin
          // leave region 1 once the slope passes -1
          if (phase == PH_R1 && !(p_reg < q_reg)) begin
            state <= S_TY;
          end else begin
            state <= S_FIN;
          end
        end
        S_TY: begin
          p_reg <= prod_d;
          state <= S_A;
        end
        S_A: begin
          q_reg <= prod_d;
          state <= S_B;
        end
        S_B: begin
          p_reg <= prod_d;
          state <= S_C;
        end
        S_C: begin
          decision <= p_reg + (prod_d <<< 2) - (k_reg <<< 2);
          phase    <= PH_R2;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!is_step || out_free) begin
            if (done_now) begin
              phase <= PH_DONE;
            end
            if (is_step) begin
              m_tvalid <= 1'b1;
              m_tlast  <= done_now;
              m_tdata  <= {{(mer_pkg::M_DATA_W - mer_pkg::M_BITS){1'b0}},
                           pend_upper, pend_lower, pend_left, pend_right};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
